// ===== design/ascii_unsigned_integer_parser_assert.svh =====
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_UNSIGNED_INTEGER_PARSER_ASSERT_SVH
`define ASCII_UNSIGNED_INTEGER_PARSER_ASSERT_SVH

// same-cycle implication
`define AUP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AUP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/aup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser - package
// Phase and status codes, character constants, parse state and result types.
// ----------------------------------------------------------------------------
package aup_pkg;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEAD   = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_HEXPFX = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OVF    = 2'd1;
    localparam logic [1:0] ST_NOCONV = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [5:0]  NO_DIGIT    = 6'd63;
    localparam logic [5:0]  RADIX_RESET = 6'd10;
    localparam logic [5:0]  RADIX_MAX   = 6'd36;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] acc;
        logic        neg;
        logic        seen;
        logic        ovf;
        logic [5:0]  arad;
        logic [15:0] pos;
    } t_state;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [15:0] end_offset;
    } t_result;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA + 8'd10;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + 8'd10;
        end else begin
            d = {2'b00, NO_DIGIT};
        end
        return d[5:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// ===== design/aup_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser - step logic
// Next parse state and optional result for one character.
// ----------------------------------------------------------------------------
module aup_step import aup_pkg::*; (
    input  logic [7:0] i_ch,
    input  logic       i_start_req,
    input  logic [5:0] i_radix,
    input  t_state     i_state,
    output t_state     o_state,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_state      s;
    logic [5:0]  d;
    logic        blank;
    logic        first_path;
    logic        radix_bad;
    logic        zero_pfx;
    logic [5:0]  r_use;
    logic        dig_ok;
    logic [70:0] prod;
    logic        td_ovf;
    logic [15:0] p;
    t_result     td_res;
    t_state      td_state;

    always_comb begin
        s = i_state;
        if (i_start_req) begin
            s = '0;
            s.phase = PH_LEAD;
        end
    end

    assign d     = digit_of(i_ch);
    assign blank = is_blank(i_ch);
    assign p     = s.pos;

    assign first_path = (s.phase == PH_SIGNED) ||
                        (s.phase == PH_LEAD && !blank && i_ch != CH_MINUS && i_ch != CH_PLUS);
    assign radix_bad  = (i_radix == 6'd1) || (i_radix > RADIX_MAX);
    assign zero_pfx   = (i_radix == 6'd0 || i_radix == 6'd16) && i_ch == CH_ZERO;
    assign r_use      = first_path ? ((i_radix == 6'd0) ? 6'd10 : i_radix) : s.arad;

    assign dig_ok = (r_use >= 6'd2) && (r_use <= RADIX_MAX) && (d < r_use);
    assign prod   = 71'(s.acc) * 71'(r_use) + 71'(d);
    assign td_ovf = s.ovf || (prod[70:64] != 7'd0);

    // digit accumulate, or terminate
    always_comb begin
        td_state = s;
        td_res   = '0;
        td_state.arad = r_use;
        if (dig_ok) begin
            td_state.ovf   = td_ovf;
            td_state.acc   = td_ovf ? s.acc : prod[63:0];
            td_state.seen  = 1'b1;
            td_state.phase = PH_DIGITS;
        end else begin
            td_state.phase = PH_IDLE;
            if (s.ovf) begin
                td_res.value      = ALL_ONES;
                td_res.status     = ST_OVF;
                td_res.end_offset = p;
            end else if (!s.seen) begin
                td_res.status = ST_NOCONV;
            end else begin
                td_res.value      = s.neg ? (64'd0 - s.acc) : s.acc;
                td_res.status     = ST_OK;
                td_res.end_offset = p;
            end
        end
    end

    always_comb begin
        o_state     = s;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (s.phase != PH_IDLE) begin
            o_state.pos = (s.pos < POS_MAX) ? s.pos + 16'd1 : s.pos;
            if (first_path) begin
                if (radix_bad) begin
                    o_state.phase = PH_IDLE;
                    o_res_valid   = 1'b1;
                    o_res.status  = ST_NOCONV;
                end else if (zero_pfx) begin
                    o_state.acc   = 64'd0;
                    o_state.seen  = 1'b1;
                    o_state.arad  = (i_radix == 6'd0) ? 6'd8 : 6'd16;
                    o_state.phase = PH_ZERO;
                end else begin
                    o_state     = td_state;
                    o_state.pos = (s.pos < POS_MAX) ? s.pos + 16'd1 : s.pos;
                    o_res_valid = !dig_ok;
                    o_res       = td_res;
                end
            end else begin
                unique case (s.phase)
                    PH_LEAD: begin
                        if (i_ch == CH_MINUS) begin
                            o_state.neg   = 1'b1;
                            o_state.phase = PH_SIGNED;
                        end else if (i_ch == CH_PLUS) begin
                            o_state.phase = PH_SIGNED;
                        end
                    end
                    PH_ZERO, PH_DIGITS: begin
                        if (s.phase == PH_ZERO && (i_ch == CH_LX || i_ch == CH_UX)) begin
                            o_state.arad  = 6'd16;
                            o_state.phase = PH_HEXPFX;
                        end else begin
                            o_state     = td_state;
                            o_state.pos = (s.pos < POS_MAX) ? s.pos + 16'd1 : s.pos;
                            o_res_valid = !dig_ok;
                            o_res       = td_res;
                        end
                    end
                    PH_HEXPFX: begin
                        if (d < 6'd16) begin
                            o_state     = td_state;
                            o_state.pos = (s.pos < POS_MAX) ? s.pos + 16'd1 : s.pos;
                            o_res_valid = !dig_ok;
                            o_res       = td_res;
                        end else begin
                            o_state.phase    = PH_IDLE;
                            o_res_valid      = 1'b1;
                            o_res.status     = ST_OK;
                            o_res.end_offset = (p > 16'd0) ? p - 16'd1 : 16'd0;
                        end
                    end
                    default: begin
                        o_state.phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== design/ascii_unsigned_integer_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser
// Parses a character stream into an unsigned 64-bit number, strtoull style.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | sink      | i_in_valid/o_in_stall | i_ch, i_start_req
//  out     | source    | o_out_valid/i_out_stall | o_value, o_status, o_end_offset
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_radix
//
//  One character a cycle unless output stall holds the input; the terminating character
//  passes the input register, then step logic into the result register, which presents it.
//  The 64x6 multiply-add in the step logic sets the cycle time.
//  Synchronous active-low reset; radix resets to 10, parser idle.
//  Output stall holds the result and, with a result waiting, the input stage.
// ----------------------------------------------------------------------------
module ascii_unsigned_integer_parser import aup_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_value,
    output logic [1:0]  o_status,
    output logic [15:0] o_end_offset,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_radix
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_start;
    logic [5:0] r_radix;
    t_state     r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_result    r_out;
    logic       adv;
    logic       step_res_valid;
    t_result    step_res;

    assign adv        = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;

    aup_step u_step (
        .i_ch        (r_in_ch),
        .i_start_req (r_in_start),
        .i_radix     (r_radix),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_in_valid && !o_in_stall) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = i_out_stall ? r_out_valid : 1'b0;
        if (adv && step_res_valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_radix     <= RADIX_RESET;
            r_state     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_radix <= i_cfg_radix;
            end
            if (adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_ch    <= i_ch;
            r_in_start <= i_start_req;
        end
        if (adv && step_res_valid) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = r_out.value;
    assign o_status     = r_out.status;
    assign o_end_offset = r_out.end_offset;

`include "ascii_unsigned_integer_parser_assert.svh"

    `AUP_ASSERT_IMP(a_noconv_zero, r_out_valid && r_out.status == ST_NOCONV,
        r_out.value == 64'd0 && r_out.end_offset == 16'd0,
        "no conversion with nonzero value or offset")
    `AUP_ASSERT_IMP(a_ovf_ones, r_out_valid && r_out.status == ST_OVF,
        r_out.value == ALL_ONES, "overflow result not saturated")
    `AUP_ASSERT_IMP(a_status_code, r_out_valid, r_out.status != 2'd3,
        "undefined status code")
    `AUP_ASSERT_NXT(a_idle_after_res, adv && step_res_valid,
        r_state.phase == PH_IDLE, "parser not idle after result")
    `AUP_ASSERT_NXT(a_in_hold, r_in_valid && r_out_valid && i_out_stall,
        r_in_valid && $stable(r_in_ch) && $stable(r_state),
        "input stage moved under stall")

endmodule

// ===== tb/tb_ascii_unsigned_integer_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII unsigned integer parser - testbench
// Feeds character strings through the parser and checks every result word
// against an in-bench parse model. A table of directed strings comes first,
// then randomised strings in all radix settings with random idling on both
// sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_ascii_unsigned_integer_parser;
    import aup_pkg::*;

    localparam int N_ITEMS    = 1300;
    localparam int LIMIT      = 600_000;
    localparam int SETTLE_CYC = 6;
    localparam int DRAIN_MAX  = 5000;
    localparam int HOLD_LONG  = 300;

    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [5:0] RADIX_AUTO = 6'd0;
    localparam logic [5:0] RADIX_MIN  = 6'd2;
    localparam logic [5:0] RADIX_OCT  = 6'd8;
    localparam logic [5:0] RADIX_DEC  = 6'd10;
    localparam logic [5:0] RADIX_HEX  = 6'd16;
    localparam logic [7:0] NOT_DIGIT  = 8'hFF;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [15:0] end_offset;
    } parse_res_t;

    typedef struct {
        logic [2:0]  ph;
        logic [63:0] acc;
        bit          neg;
        bit          seen;
        bit          ovf;
        logic [5:0]  arad;
        logic [15:0] pos;
    } parse_state_t;

    typedef enum logic {ROW_CHAR, ROW_RADIX} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        logic [5:0] rdx;
        logic [7:0] ch;
        logic       st;
        logic       typed;
        parse_res_t res;
    } row_t;

    localparam parse_res_t NONE = '0;
    localparam int NROWS = 36;

    row_t dir_tab [NROWS] = '{
        '{ROW_CHAR,  6'd0,  CH_NINE,  1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'hFF,    1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h37,    1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_NUL,   1'b0, 1'b1, '{64'd7, ST_OK, 16'd1}},
        '{ROW_CHAR,  6'd0,  CH_SPACE, 1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_MINUS, 1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h31,    1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_NUL,   1'b0, 1'b1, '{ALL_ONES, ST_OK, 16'd3}},
        '{ROW_CHAR,  6'd0,  CH_PLUS,  1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_LA,    1'b0, 1'b1, '{64'd0, ST_NOCONV, 16'd0}},
        '{ROW_CHAR,  6'd0,  CH_NINE,  1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h34,    1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'hFF,    1'b0, 1'b1, '{64'd4, ST_OK, 16'd1}},
        '{ROW_RADIX, 6'd16, CH_NUL,   1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_ZERO,  1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_LX,    1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h67,    1'b0, 1'b1, '{64'd0, ST_OK, 16'd1}},
        '{ROW_RADIX, 6'd1,  CH_NUL,   1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_CR,    1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h31,    1'b0, 1'b1, '{64'd0, ST_NOCONV, 16'd0}},
        '{ROW_RADIX, 6'd63, CH_NUL,   1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_ZERO,  1'b1, 1'b1, '{64'd0, ST_NOCONV, 16'd0}},
        '{ROW_RADIX, 6'd0,  CH_NUL,   1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_ZERO,  1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h37,    1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h38,    1'b0, 1'b0, NONE},
        '{ROW_RADIX, 6'd36, CH_NUL,   1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_LZ,    1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_UZ,    1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  CH_NUL,   1'b0, 1'b0, NONE},
        '{ROW_RADIX, 6'd10, CH_NUL,   1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h31,    1'b1, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h32,    1'b0, 1'b0, NONE},
        '{ROW_RADIX, 6'd16, CH_NUL,   1'b0, 1'b0, NONE},
        '{ROW_CHAR,  6'd0,  8'h66,    1'b0, 1'b1, '{64'd12, ST_OK, 16'd2}},
        '{ROW_CHAR,  6'd0,  CH_NUL,   1'b0, 1'b0, NONE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_ch;
    logic        i_start_req;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_value;
    logic [1:0]  o_status;
    logic [15:0] o_end_offset;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_radix;

    parse_state_t ps;
    logic [5:0]   cur_radix;
    parse_res_t   number_q [$];

    bit tx_gaps;
    bit rx_gaps;
    int hold_cnt;
    int errors;
    int cycle_cnt;
    int n_items;
    int n_sent;
    int n_res;
    int n_ovf;
    int n_noconv;
    int n_cfg;

    ascii_unsigned_integer_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_ch         (i_ch),
        .i_start_req  (i_start_req),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_status     (o_status),
        .o_end_offset (o_end_offset),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_radix  (i_cfg_radix)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("timed out after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [7:0] char_val(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return c - CH_ZERO;
        end
        if (lc >= CH_LA && lc <= CH_LZ) begin
            return lc - CH_LA + 8'd10;
        end
        return NOT_DIGIT;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) begin
            return CH_ZERO + 8'(d);
        end
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
    endfunction

    function automatic bit digit_step(input logic [7:0] c, input logic [15:0] p,
                                      output parse_res_t r);
        logic [7:0]  d;
        logic [69:0] wide;
        r = '0;
        d = char_val(c);
        if (ps.arad >= RADIX_MIN && ps.arad <= RADIX_MAX && d < 8'(ps.arad)) begin
            wide = 70'(ps.acc) * 70'(ps.arad) + 70'(d);
            if (ps.ovf || wide[69:64] != 6'd0) begin
                ps.ovf = 1'b1;
            end else begin
                ps.acc = wide[63:0];
            end
            ps.seen = 1'b1;
            ps.ph   = PH_DIGITS;
            return 1'b0;
        end
        if (ps.ovf) begin
            r.value      = ALL_ONES;
            r.status     = ST_OVF;
            r.end_offset = p;
        end else if (!ps.seen) begin
            r.status = ST_NOCONV;
        end else begin
            r.value      = ps.neg ? 64'd0 - ps.acc : ps.acc;
            r.status     = ST_OK;
            r.end_offset = p;
        end
        return 1'b1;
    endfunction

    // base is fixed here, at the first character past blanks and sign
    function automatic bit first_char(input logic [7:0] c, input logic [15:0] p,
                                      output parse_res_t r);
        r = '0;
        if (cur_radix == 6'd1 || cur_radix > RADIX_MAX) begin
            r.status = ST_NOCONV;
            return 1'b1;
        end
        if ((cur_radix == RADIX_AUTO || cur_radix == RADIX_HEX) && c == CH_ZERO) begin
            ps.acc  = '0;
            ps.seen = 1'b1;
            ps.arad = (cur_radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
            ps.ph   = PH_ZERO;
            return 1'b0;
        end
        ps.arad = (cur_radix == RADIX_AUTO) ? RADIX_DEC : cur_radix;
        return digit_step(c, p, r);
    endfunction

    function automatic bit parse_char(input logic [7:0] c, input bit st,
                                      output parse_res_t r);
        logic [15:0] p;
        bit          done;
        r    = '0;
        done = 1'b0;
        if (st) begin
            ps = '{PH_LEAD, 64'd0, 1'b0, 1'b0, 1'b0, 6'd0, 16'd0};
        end
        if (ps.ph == PH_IDLE) begin
            return 1'b0;
        end
        p = ps.pos;
        if (ps.pos != POS_MAX) begin
            ps.pos++;
        end
        case (ps.ph)
            PH_LEAD: begin
                if (c == CH_MINUS) begin
                    ps.neg = 1'b1;
                    ps.ph  = PH_SIGNED;
                end else if (c == CH_PLUS) begin
                    ps.ph = PH_SIGNED;
                end else if (!is_space(c)) begin
                    done = first_char(c, p, r);
                end
            end
            PH_SIGNED: begin
                done = first_char(c, p, r);
            end
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    ps.arad = RADIX_HEX;
                    ps.ph   = PH_HEXPFX;
                end else begin
                    done = digit_step(c, p, r);
                end
            end
            PH_HEXPFX: begin
                if (char_val(c) < 8'(RADIX_HEX)) begin
                    done = digit_step(c, p, r);
                end else begin
                    // "0x" with nothing after it: only the zero counts
                    r.status     = ST_OK;
                    r.end_offset = (p != 16'd0) ? p - 16'd1 : 16'd0;
                    done         = 1'b1;
                end
            end
            PH_DIGITS: begin
                done = digit_step(c, p, r);
            end
            default: begin
                ps.ph = PH_IDLE;
            end
        endcase
        if (done) begin
            ps.ph = PH_IDLE;
        end
        return done;
    endfunction

    task automatic send_char(input logic [7:0] c, input bit st, input bit typed = 1'b0,
                             input parse_res_t tr = '0);
        int         gap;
        bit         ignored;
        bit         got;
        parse_res_t pr;
        gap = tx_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_ch        = c;
        i_start_req = st;
        do @(posedge i_clk); while (o_in_stall);
        ignored = (ps.ph == PH_IDLE) && !st;
        got     = parse_char(c, st, pr);
        if (!ignored) begin
            n_items++;
        end
        n_sent++;
        if (typed) begin
            number_q.push_back(tr);
        end else if (got) begin
            number_q.push_back(pr);
        end
    endtask

    // a character that gives no result may still be in flight: pause on top
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (number_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [5:0] rdx);
        settle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_radix = rdx;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_radix = rdx;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin : result_side
        parse_res_t e;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = (hold_cnt != 0);
            if (hold_cnt != 0) begin
                hold_cnt--;
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                n_res++;
                if (o_status == ST_OVF) begin
                    n_ovf++;
                end
                if (o_status == ST_NOCONV) begin
                    n_noconv++;
                end
                if (number_q.size() == 0) begin
                    $error("unexpected word: value %h status %0d offset %0d",
                           o_value, o_status, o_end_offset);
                    errors++;
                end else begin
                    e = number_q.pop_front();
                    if (o_value !== e.value) begin
                        $error("value: expected %h, got %h", e.value, o_value);
                        errors++;
                    end
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_status);
                        errors++;
                    end
                    if (o_end_offset !== e.end_offset) begin
                        $error("end_offset: expected %0d, got %0d",
                               e.end_offset, o_end_offset);
                        errors++;
                    end
                end
                hold_cnt = rx_gaps ? $urandom_range(0, 14) : 0;
                // long hold-offs so the parser backs up into its input
                if (n_res == 30 || n_res == 120) begin
                    hold_cnt = HOLD_LONG;
                end
            end
        end
    end

    initial begin : char_side
        int           j;
        int           n;
        int           k;
        int           r;
        int           w;
        bit           paused;
        logic [63:0]  v;
        logic [7:0]   str [$];
        int           dq [$];

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_ch        = '0;
        i_start_req = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_radix = '0;
        ps          = '{PH_IDLE, 64'd0, 1'b0, 1'b0, 1'b0, 6'd0, 16'd0};
        cur_radix   = RADIX_RESET;
        paused      = 1'b0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_RADIX) begin
                write_radix(dir_tab[i].rdx);
            end else begin
                send_char(dir_tab[i].ch, dir_tab[i].st, dir_tab[i].typed, dir_tab[i].res);
            end
        end

        while (n_items < N_ITEMS) begin
            if ($urandom_range(0, 13) == 0) begin
                case ($urandom_range(0, 9))
                    0:       k = RADIX_AUTO;
                    1:       k = RADIX_DEC;
                    2:       k = RADIX_HEX;
                    3:       k = RADIX_MIN;
                    4:       k = RADIX_OCT;
                    5:       k = RADIX_MAX;
                    6:       k = 1;
                    7:       k = $urandom_range(37, 63);
                    default: k = $urandom_range(2, 36);
                endcase
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_gaps = ($urandom_range(0, 3) != 0);
                write_radix(6'(k));
            end
            if (!paused && n_items >= N_ITEMS / 2) begin
                paused = 1'b1;
                settle();
            end
            if ($urandom_range(0, 14) == 0) begin
                n = $urandom_range(1, 3);
                for (j = 0; j < n; j++) begin
                    send_char(8'($urandom_range(0, 255)), 1'b0);
                end
            end

            str.delete();
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 3);
                for (j = 0; j < n; j++) begin
                    k = $urandom_range(8, 13);
                    str.push_back(k == 8 ? CH_SPACE : 8'(k));
                end
            end
            case ($urandom_range(0, 3))
                0:       str.push_back(CH_MINUS);
                1:       str.push_back(CH_PLUS);
                default: ;
            endcase
            r = cur_radix;
            if (cur_radix == RADIX_AUTO) begin
                case ($urandom_range(0, 2))
                    0: r = RADIX_DEC;
                    1: begin
                        r = RADIX_OCT;
                        str.push_back(CH_ZERO);
                    end
                    default: begin
                        r = RADIX_HEX;
                        str.push_back(CH_ZERO);
                        str.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                    end
                endcase
            end else if (cur_radix == RADIX_HEX && $urandom_range(0, 2) == 0) begin
                str.push_back(CH_ZERO);
                str.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            end else if (cur_radix < RADIX_MIN || cur_radix > RADIX_MAX) begin
                r = RADIX_DEC;
            end
            n = 0;
            case ($urandom_range(0, 9))
                0: ;
                1: begin
                    // the digits of all ones, last one sometimes bumped past it
                    dq.delete();
                    v = ALL_ONES;
                    while (v != 0) begin
                        dq.push_front(int'(v % 64'(r)));
                        v = v / 64'(r);
                    end
                    if ($urandom_range(0, 1) && dq[$] < r - 1) begin
                        dq[$] = $urandom_range(dq[$] + 1, r - 1);
                    end
                    foreach (dq[i]) begin
                        str.push_back(digit_char(dq[i]));
                    end
                end
                2:       n = $urandom_range(10, 70);
                default: n = $urandom_range(1, 8);
            endcase
            for (j = 0; j < n; j++) begin
                str.push_back(digit_char($urandom_range(0, r - 1)));
            end
            str.push_back($urandom_range(0, 4) < 3 ? CH_NUL : 8'($urandom_range(0, 255)));
            for (j = 1; j < str.size(); j++) begin
                if ($urandom_range(0, 29) == 0) begin
                    str[j] = 8'($urandom_range(0, 255));
                end
            end
            if (str.size() > 1 && $urandom_range(0, 24) == 0) begin
                str = str[0:$urandom_range(0, str.size() - 2)];
            end
            foreach (str[i]) begin
                send_char(str[i], i == 0);
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        w = 0;
        while (number_q.size() != 0 && w < DRAIN_MAX) begin
            @(posedge i_clk);
            w++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (number_q.size() != 0) begin
            $error("%0d result words never arrived", number_q.size());
            errors++;
        end

        $display("%0d characters sent, %0d results checked (%0d overflow, %0d no conversion)",
                 n_sent, n_res, n_ovf, n_noconv);
        $display("%0d radix writes; %0d directed rows, then random strings in every radix",
                 n_cfg, NROWS);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/aup_pkg.sv
design/aup_step.sv
design/ascii_unsigned_integer_parser.sv
tb/tb_ascii_unsigned_integer_parser.sv
